// File: rtl/core/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Types, codes, store layout and the instruction decoder shared by the shell
// strain-displacement block.
// ----------------------------------------------------------------------------
package ssd_pkg;

	localparam int ADDR_W       = 6;
	localparam int STORE_DEPTH  = 1 << ADDR_W;
	localparam int NODE_LIMIT   = 4;
	localparam int DOF_PER_NODE = 5;
	localparam int FRAC         = 24;
	localparam int MAG_W        = 48;
	localparam int PRO_LEN      = 16;

	typedef logic [ADDR_W-1:0] addr_t;

	// Store layout: loaded operands first, then scratch for intermediates.
	localparam addr_t R_BASE     = 6'd0;
	localparam addr_t OP_BASE    = 6'd9;
	localparam addr_t V_BASE     = 6'd23;
	localparam addr_t D_BASE     = 6'd26;
	localparam addr_t DZ_BASE    = 6'd29;
	localparam addr_t W_BASE     = 6'd32;
	localparam addr_t NZ_ADDR    = 6'd38;
	localparam addr_t CONST_ONE  = 6'd62;
	localparam addr_t CONST_ZERO = 6'd63;

	typedef enum logic [1:0] {
		KIND_ROT,
		KIND_OPND,
		KIND_COMP
	} item_kind_t;

	typedef enum logic [1:0] {
		MK_FULL,
		MK_MEMB,
		MK_TRANS,
		MK_MASS
	} matrix_kind_t;

	typedef enum logic [1:0] {
		REG_MATRIX_KIND,
		REG_QUAD_MODE
	} cfg_reg_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_BAD,
		S_ISSUE,
		S_WAIT
	} seq_state_t;

	typedef enum logic [3:0] {
		M_IDLE,
		M_RD,
		M_OPS,
		M_P0,
		M_P1,
		M_P2,
		M_P3,
		M_MAG,
		M_ACC,
		M_SAT,
		M_NEG,
		M_DONE
	} mac_state_t;

	// One instruction: a sum of up to three rounded products, optionally
	// negated, written to scratch or emitted as a matrix entry.
	typedef struct packed {
		logic [1:0]  last_term;
		addr_t [2:0] a;
		addr_t [2:0] b;
		logic        neg;
		logic        emit;
		addr_t       dest;
	} instr_t;

	typedef struct packed {
		logic start;
		logic ack;
	} mac_ctl_t;

	typedef struct packed {
		logic idle;
		logic done;
	} mac_sts_t;

	function automatic instr_t ssd_decode(logic emit_ph, logic [3:0] pidx,
			matrix_kind_t mk, logic [2:0] r, logic [2:0] k);
		instr_t ins;
		int     j;
		int     grp;
		int     br;
		int     xs [2];
		int     ys [2];
		addr_t  src;
		ins = '0;
		j   = 0;
		grp = 0;
		br  = 0;
		xs  = '{0, 0};
		ys  = '{0, 0};
		src = OP_BASE;
		for (int t = 0; t < 3; t++) begin
			ins.a[t] = CONST_ZERO;
			ins.b[t] = CONST_ZERO;
		end
		if (!emit_ph) begin
			if (pidx < 4'd3) begin
				ins.last_term = 2'd1;
				ins.a[0] = OP_BASE + 6'd7;
				ins.b[0] = OP_BASE + 6'(pidx);
				ins.a[1] = OP_BASE + 6'd4 + 6'(pidx);
				ins.b[1] = OP_BASE + 6'd3;
				ins.dest = V_BASE + 6'(pidx);
			end else if (pidx == 4'(PRO_LEN - 1)) begin
				ins.a[0] = OP_BASE;
				ins.b[0] = OP_BASE + 6'd7;
				ins.dest = NZ_ADDR;
			end else begin
				if (pidx < 4'd6) begin
					grp = 0;
					j   = int'(pidx) - 3;
				end else if (pidx < 4'd9) begin
					grp = 1;
					j   = int'(pidx) - 6;
				end else if (pidx < 4'd12) begin
					grp = 2;
					j   = int'(pidx) - 9;
				end else begin
					grp = 3;
					j   = int'(pidx) - 12;
				end
				case (grp)
					0: src = OP_BASE;
					1: src = V_BASE;
					2: src = OP_BASE + 6'd11;
					default: src = OP_BASE + 6'd8;
				endcase
				for (int i = 0; i < 3; i++) begin
					ins.a[i] = R_BASE + 6'(3 * j + i);
					ins.b[i] = src + 6'(i);
				end
				case (grp)
					0: ins.dest = D_BASE + 6'(j);
					1: ins.dest = DZ_BASE + 6'(j);
					2: ins.dest = W_BASE + 6'(2 * j);
					default: ins.dest = W_BASE + 6'(2 * j + 1);
				endcase
				ins.neg       = (grp == 2);
				ins.last_term = 2'd2;
			end
		end else begin
			ins.emit = 1'b1;
			if (mk == MK_MASS) begin
				if (k < 3'd3) begin
					if (k == r) begin
						ins.a[0] = OP_BASE;
						ins.b[0] = CONST_ONE;
					end
				end else if (k == 3'd3) begin
					ins.a[0] = OP_BASE + 6'd11 + 6'(r);
					ins.b[0] = NZ_ADDR;
					ins.neg  = 1'b1;
				end else begin
					ins.a[0] = OP_BASE + 6'd8 + 6'(r);
					ins.b[0] = NZ_ADDR;
				end
			end else begin
				br = int'(r);
				if (mk == MK_MEMB) br = br + 2;
				if (mk == MK_TRANS) br = br + 3;
				// Each strain row pairs a lamina axis with a derivative axis.
				case (br)
					0: xs = '{0, 0};
					1: xs = '{1, 0};
					2: xs = '{0, 1};
					3: xs = '{2, 0};
					default: xs = '{1, 2};
				endcase
				case (br)
					0: ys = '{0, 0};
					1: ys = '{1, 0};
					2: ys = '{1, 0};
					3: ys = '{0, 2};
					default: ys = '{2, 1};
				endcase
				ins.last_term = (br >= 2) ? 2'd1 : 2'd0;
				for (int t = 0; t < 2; t++) begin
					if (k < 3'd3) begin
						ins.a[t] = R_BASE + 6'(3 * xs[t] + int'(k));
						ins.b[t] = D_BASE + 6'(ys[t]);
					end else begin
						ins.a[t] = W_BASE + 6'(2 * xs[t] + int'(k) - 3);
						ins.b[t] = DZ_BASE + 6'(ys[t]);
					end
				end
			end
		end
		return ins;
	endfunction

endpackage

// File: rtl/core/ssd_ifs.sv
// ----------------------------------------------------------------------------
// ssd_ifs
// Handshake channels of the strain-displacement block: items, matrix entries
// and register writes.
// ----------------------------------------------------------------------------
interface ssd_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [3:0]         slot;
	logic signed [31:0] load_value;
	logic [1:0]         node;

	modport source(output valid, kind, slot, load_value, node, input ready);
	modport sink(input valid, kind, slot, load_value, node, output ready);
endinterface

interface ssd_entry_if;
	logic               valid;
	logic               ready;
	logic [2:0]         row;
	logic [4:0]         column;
	logic signed [31:0] entry_value;
	logic               last;
	logic               bad_node;

	modport source(output valid, row, column, entry_value, last, bad_node, input ready);
	modport sink(input valid, row, column, entry_value, last, bad_node, output ready);
endinterface

interface ssd_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/core/ssd_store.sv
// ----------------------------------------------------------------------------
// ssd_store
// Operand and scratch memory: one write port, two registered read ports.
// Per-entry valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module ssd_store #(
	parameter int VALUE_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      we,
	input  ssd_pkg::addr_t            waddr,
	input  logic [VALUE_BITS-1:0]     wdata,
	input  ssd_pkg::addr_t            raddr_a,
	input  ssd_pkg::addr_t            raddr_b,
	output logic [VALUE_BITS-1:0]     rdata_a,
	output logic [VALUE_BITS-1:0]     rdata_b
);
	import ssd_pkg::*;

	logic [VALUE_BITS-1:0]  mem [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] vld_q;
	logic [VALUE_BITS-1:0]  data_a_q;
	logic [VALUE_BITS-1:0]  data_b_q;
	logic                   vld_a_q;
	logic                   vld_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		data_a_q <= mem[raddr_a];
		data_b_q <= mem[raddr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			vld_a_q <= 1'b0;
			vld_b_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			vld_a_q <= vld_q[raddr_a];
			vld_b_q <= vld_q[raddr_b];
		end
	end

	assign rdata_a = vld_a_q ? data_a_q : '0;
	assign rdata_b = vld_b_q ? data_b_q : '0;

endmodule

// File: rtl/core/ssd_mac.sv
// ----------------------------------------------------------------------------
// ssd_mac
// Executes one instruction: reads each operand pair from the store, forms the
// rounded, saturated fixed-point product on a shared 24x24 multiplier in four
// partial products, sums the terms, saturates and optionally negates.
// ----------------------------------------------------------------------------
module ssd_mac #(
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ssd_pkg::mac_ctl_t     ctl,
	input  ssd_pkg::instr_t       instr,
	input  logic [VALUE_BITS-1:0] rdata_a,
	input  logic [VALUE_BITS-1:0] rdata_b,
	output ssd_pkg::addr_t        raddr_a,
	output ssd_pkg::addr_t        raddr_b,
	output ssd_pkg::mac_sts_t     sts,
	output logic [VALUE_BITS-1:0] result
);
	import ssd_pkg::*;

	localparam int VB    = VALUE_BITS;
	localparam int ACC_W = MAG_W + 4;
	localparam logic [ACC_W-1:0] LIM_W = ACC_W'(1) << (VB - 1);
	localparam logic [VB-1:0] LIM   = {1'b1, {(VB-1){1'b0}}};
	localparam logic [VB-1:0] PMAX  = {1'b0, {(VB-1){1'b1}}};
	localparam logic signed [VB+1:0] SUM_MAX = {3'b000, {(VB-1){1'b1}}};
	localparam logic signed [VB+1:0] SUM_MIN = {3'b111, {(VB-1){1'b0}}};

	mac_state_t state_q, state_d;
	logic [1:0] tq_q;

	logic [MAG_W-1:0]       ua_q;
	logic [MAG_W-1:0]       ub_q;
	logic                   neg_q;
	logic [MAG_W-1:0]       pp_q;
	logic [ACC_W-1:0]       acc_q;
	logic [VB-1:0]          mag_q;
	logic signed [VB+1:0]   sum_q;
	logic [VB-1:0]          res_q;

	logic [VB-1:0]    abs_a;
	logic [VB-1:0]    abs_b;
	logic [MAG_W-1:0] ma;
	logic [MAG_W-1:0] mb;
	logic             sa;
	logic             sb;
	logic [23:0]      mx;
	logic [23:0]      my;
	logic [MAG_W-1:0] pp_d;
	logic [ACC_W-1:0] mag_sum;
	logic signed [VB:0] prod;

	assign raddr_a = instr.a[tq_q];
	assign raddr_b = instr.b[tq_q];
	assign result  = res_q;

	// Operand magnitudes; the constant codes bypass the store.
	always_comb begin
		sa    = rdata_a[VB-1];
		sb    = rdata_b[VB-1];
		abs_a = sa ? (~rdata_a + 1'b1) : rdata_a;
		abs_b = sb ? (~rdata_b + 1'b1) : rdata_b;
		ma    = MAG_W'(abs_a);
		mb    = MAG_W'(abs_b);
		if (raddr_a == CONST_ZERO) begin
			sa = 1'b0;
			ma = '0;
		end else if (raddr_a == CONST_ONE) begin
			sa = 1'b0;
			ma = MAG_W'(1) << FRAC;
		end
		if (raddr_b == CONST_ZERO) begin
			sb = 1'b0;
			mb = '0;
		end else if (raddr_b == CONST_ONE) begin
			sb = 1'b0;
			mb = MAG_W'(1) << FRAC;
		end
	end

	always_comb begin
		case (state_q)
			M_P1: begin
				mx = ua_q[47:24];
				my = ub_q[23:0];
			end
			M_P2: begin
				mx = ua_q[23:0];
				my = ub_q[47:24];
			end
			M_P3: begin
				mx = ua_q[47:24];
				my = ub_q[47:24];
			end
			default: begin
				mx = ua_q[23:0];
				my = ub_q[23:0];
			end
		endcase
		pp_d    = mx * my;
		mag_sum = acc_q + (ACC_W'(pp_q) << FRAC);
		// A negative product may reach the full negative limit.
		if (neg_q) begin
			prod = -$signed({1'b0, mag_q});
		end else begin
			prod = $signed({1'b0, (mag_q == LIM) ? PMAX : mag_q});
		end
	end

	always_comb begin
		state_d   = state_q;
		sts.idle  = 1'b0;
		sts.done  = 1'b0;
		unique case (state_q)
			M_IDLE: begin
				sts.idle = 1'b1;
				if (ctl.start) state_d = M_RD;
			end
			M_RD:  state_d = M_OPS;
			M_OPS: state_d = M_P0;
			M_P0:  state_d = M_P1;
			M_P1:  state_d = M_P2;
			M_P2:  state_d = M_P3;
			M_P3:  state_d = M_MAG;
			M_MAG: state_d = M_ACC;
			M_ACC: state_d = (tq_q == instr.last_term) ? M_SAT : M_RD;
			M_SAT: state_d = M_NEG;
			M_NEG: state_d = M_DONE;
			M_DONE: begin
				sts.done = 1'b1;
				if (ctl.ack) state_d = M_IDLE;
			end
			default: state_d = M_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			tq_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == M_IDLE) begin
				tq_q <= '0;
			end else if (state_q == M_ACC && tq_q != instr.last_term) begin
				tq_q <= tq_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			M_IDLE: sum_q <= '0;
			M_OPS: begin
				ua_q  <= ma;
				ub_q  <= mb;
				neg_q <= sa ^ sb;
			end
			M_P0: pp_q <= pp_d;
			M_P1: begin
				pp_q  <= pp_d;
				acc_q <= ACC_W'(({1'b0, pp_q} + (49'd1 << (FRAC - 1))) >> FRAC);
			end
			M_P2: begin
				pp_q  <= pp_d;
				acc_q <= acc_q + ACC_W'(pp_q);
			end
			M_P3: begin
				pp_q  <= pp_d;
				acc_q <= acc_q + ACC_W'(pp_q);
			end
			M_MAG: begin
				if (pp_q >= (MAG_W'(1) << 24) || mag_sum > LIM_W) begin
					mag_q <= LIM;
				end else begin
					mag_q <= mag_sum[VB-1:0];
				end
			end
			M_ACC: sum_q <= sum_q + {prod[VB], prod};
			M_SAT: begin
				if (sum_q > SUM_MAX) begin
					res_q <= PMAX;
				end else if (sum_q < SUM_MIN) begin
					res_q <= LIM;
				end else begin
					res_q <= sum_q[VB-1:0];
				end
			end
			M_NEG: begin
				if (instr.neg) begin
					res_q <= (res_q == LIM) ? PMAX : (~res_q + 1'b1);
				end
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/core/shell_strain_displacement_block_top.sv
// ----------------------------------------------------------------------------
// shell_strain_displacement_block_top
// Builds one node's columns of a degenerated shell element's
// strain-displacement matrix from loaded rotation and node operands.
// ----------------------------------------------------------------------------
//  channel | dir | handshake    | payload
//  item    | in  | valid/ready  | kind, slot, load_value, node
//  entry   | out | valid/ready  | row, column, entry_value, last, bad_node
//  cfg     | in  | valid/ready  | index, data (matrix_kind, quad_mode)
//
// A load request is written to the store as it is accepted. A compute
// request runs a fixed sequence of instructions on one shared 24x24
// multiplier, four passes per product: first the shared intermediates,
// then one instruction per entry of the block.
// A missing node gives its single entry.
// Reset sets the control registers and clears the store's valid bits; no clearing pass.
// A stalled entry channel holds the sequencer at its next emitted entry.
// ----------------------------------------------------------------------------
module shell_strain_displacement_block_top #(
	parameter int VALUE_BITS = 32
) (
	input logic          clk,
	input logic          arst_n,
	ssd_item_if.sink     item,
	ssd_entry_if.source  entry,
	ssd_cfg_if.sink      cfg
);
	import ssd_pkg::*;

	localparam int VB = VALUE_BITS;
	localparam logic signed [63:0] VMAX = (64'sd1 <<< (VB - 1)) - 64'sd1;
	localparam logic signed [63:0] VMIN = -(64'sd1 <<< (VB - 1));
	localparam logic signed [63:0] EMAX = 64'sd2147483647;
	localparam logic signed [63:0] EMIN = -64'sd2147483648;

	matrix_kind_t mkind_q;
	logic         quad_q;

	seq_state_t state_q, state_d;
	logic       emit_ph_q;
	logic [3:0] pidx_q;
	logic [2:0] r_q;
	logic [2:0] k_q;
	logic [1:0] node_q;

	logic               out_valid_q;
	logic [2:0]         out_row_q;
	logic [4:0]         out_col_q;
	logic signed [31:0] out_val_q;
	logic               out_last_q;
	logic               out_bad_q;

	instr_t     instr;
	mac_ctl_t   ctl;
	mac_sts_t   sts;
	logic [VB-1:0] res;
	addr_t      raddr_a;
	addr_t      raddr_b;
	logic [VB-1:0] rdata_a;
	logic [VB-1:0] rdata_b;

	logic          accept;
	logic          is_bad;
	logic          load_ok;
	logic          out_free;
	logic          last_ent;
	logic          ack;
	logic [2:0]    nrows;
	logic [2:0]    ncols;
	logic [4:0]    base;
	logic          mem_we;
	addr_t         mem_waddr;
	logic [VB-1:0] mem_wdata;
	logic signed [63:0] load_w;
	logic signed [63:0] res_w;
	logic signed [31:0] res32;
	logic [VB-1:0]      load_sat;

	// Register writes.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mkind_q <= MK_FULL;
			quad_q  <= 1'b1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MATRIX_KIND: mkind_q <= matrix_kind_t'(cfg.data);
				REG_QUAD_MODE:   quad_q  <= cfg.data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (mkind_q)
			MK_MEMB: begin
				nrows = 3'd1;
				ncols = 3'd3;
			end
			MK_TRANS: begin
				nrows = 3'd2;
				ncols = 3'd5;
			end
			MK_MASS: begin
				nrows = 3'd3;
				ncols = 3'd5;
			end
			default: begin
				nrows = 3'd5;
				ncols = 3'd5;
			end
		endcase
	end

	assign instr    = ssd_decode(emit_ph_q, pidx_q, mkind_q, r_q, k_q);
	assign item.ready = (state_q == S_IDLE);
	assign accept   = item.valid && item.ready;
	assign is_bad   = {1'b0, item.node} >= (quad_q ? 3'(NODE_LIMIT) : 3'd3);
	assign out_free = !out_valid_q || entry.ready;
	assign last_ent = emit_ph_q && (r_q == nrows - 3'd1) && (k_q == ncols - 3'd1);
	assign ack      = (state_q == S_WAIT) && sts.done && (!instr.emit || out_free);
	assign ctl.start = (state_q == S_ISSUE);
	assign ctl.ack   = ack;
	assign base     = 5'(node_q) * 5'(DOF_PER_NODE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && item.kind == KIND_COMP) begin
					state_d = is_bad ? S_BAD : S_ISSUE;
				end
			end
			S_BAD:   if (out_free) state_d = S_IDLE;
			S_ISSUE: state_d = S_WAIT;
			S_WAIT:  if (ack) state_d = last_ent ? S_IDLE : S_ISSUE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			emit_ph_q <= 1'b0;
			pidx_q    <= '0;
			r_q       <= '0;
			k_q       <= '0;
			node_q    <= '0;
		end else begin
			state_q <= state_d;
			if (accept && item.kind == KIND_COMP) begin
				emit_ph_q <= 1'b0;
				pidx_q    <= '0;
				r_q       <= '0;
				k_q       <= '0;
				node_q    <= item.node;
			end else if (ack) begin
				if (!emit_ph_q) begin
					if (pidx_q == 4'(PRO_LEN - 1)) begin
						emit_ph_q <= 1'b1;
					end else begin
						pidx_q <= pidx_q + 4'd1;
					end
				end else if (k_q == ncols - 3'd1) begin
					k_q <= '0;
					r_q <= r_q + 3'd1;
				end else begin
					k_q <= k_q + 3'd1;
				end
			end
		end
	end

	// Loads saturate to the working width; entries saturate to 32 bits.
	always_comb begin
		load_w = {{32{item.load_value[31]}}, item.load_value};
		if (load_w > VMAX) begin
			load_sat = VMAX[VB-1:0];
		end else if (load_w < VMIN) begin
			load_sat = VMIN[VB-1:0];
		end else begin
			load_sat = load_w[VB-1:0];
		end
		res_w = {{(64-VB){res[VB-1]}}, res};
		if (res_w > EMAX) begin
			res32 = EMAX[31:0];
		end else if (res_w < EMIN) begin
			res32 = EMIN[31:0];
		end else begin
			res32 = res_w[31:0];
		end
	end

	always_comb begin
		load_ok = 1'b0;
		case (item.kind)
			KIND_ROT:  load_ok = (item.slot < 4'd9);
			KIND_OPND: load_ok = (item.slot < 4'd14);
			default:   load_ok = 1'b0;
		endcase
		if (accept) begin
			mem_we    = load_ok;
			mem_waddr = (item.kind == KIND_ROT) ? R_BASE + 6'(item.slot)
				: OP_BASE + 6'(item.slot);
			mem_wdata = load_sat;
		end else begin
			mem_we    = ack && !instr.emit;
			mem_waddr = instr.dest;
			mem_wdata = res;
		end
	end

	ssd_store #(
		.VALUE_BITS(VB)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	ssd_mac #(
		.VALUE_BITS(VB)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.instr   (instr),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.sts     (sts),
		.result  (res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((ack && instr.emit) || (state_q == S_BAD && out_free)) begin
			out_valid_q <= 1'b1;
		end else if (entry.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_BAD && out_free) begin
			out_row_q  <= '0;
			out_col_q  <= base;
			out_val_q  <= '0;
			out_last_q <= 1'b1;
			out_bad_q  <= 1'b1;
		end else if (ack && instr.emit) begin
			out_row_q  <= r_q;
			out_col_q  <= base + 5'(k_q);
			out_val_q  <= res32;
			out_last_q <= last_ent;
			out_bad_q  <= 1'b0;
		end
	end

	assign entry.valid       = out_valid_q;
	assign entry.row         = out_row_q;
	assign entry.column      = out_col_q;
	assign entry.entry_value = out_val_q;
	assign entry.last        = out_last_q;
	assign entry.bad_node    = out_bad_q;

	a_bad_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_bad_q) |-> out_last_q)
		else $error("missing-node entry not marked last");

	a_mac_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> sts.idle)
		else $error("multiply unit busy while sequencer idle");

	a_scratch_only: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && state_q != S_IDLE) |-> (mem_waddr >= V_BASE))
		else $error("computed result written over a loaded operand");

	a_wait_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WAIT && !sts.done) |=> (state_q == S_WAIT))
		else $error("sequencer left wait before the instruction finished");

endmodule
